// ----- rtl/lz77_hash_chain_encoder_macros.svh -----
// Assertion macros for the LZ77 hash chain encoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef LZ77_HASH_CHAIN_ENCODER_MACROS_SVH
`define LZ77_HASH_CHAIN_ENCODER_MACROS_SVH

// Same-cycle implication
`define LZH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LZH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lzh_pkg.sv -----
// Shared types and constants of the LZ77 hash chain encoder.
// No dependencies.
`timescale 1ns / 1ps
package lzh_pkg;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned DIST_W    = 15;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned HASH_W    = 8;
  localparam int unsigned HASH_ENTRIES = 256;

  localparam logic [LEN_W-1:0]   MAX_MATCH   = 9'd258;
  localparam logic [LEN_W-1:0]   MIN_MATCH   = 9'd3;
  localparam logic [HASH_W-1:0]  HASH_MULT   = 8'd13;
  localparam logic [LIMIT_W-1:0] CHAIN_LIMIT_RST = 7'd10;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for an input transfer
    ST_HREAD,  // address one hash byte
    ST_HACC,   // fold hash byte
    ST_HEAD,   // head table read latency
    ST_HEADR,  // update head and chain link
    ST_CAND,   // check next candidate
    ST_CRD,    // address compare bytes
    ST_CCMP,   // compare one byte pair
    ST_EVAL,   // keep best, follow link
    ST_EMIT    // write token register
  } state_e;
endpackage

// ----- rtl/lzh_if.sv -----
// Handshake channels of the LZ77 hash chain encoder.
// Depends on nothing.
`timescale 1ns / 1ps
interface lzh_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, kind, data_byte, last_byte, input ready);
  modport sink   (input valid, kind, data_byte, last_byte, output ready);
endinterface

interface lzh_tok_if;
  logic        valid;
  logic        ready;
  logic        is_literal;
  logic [7:0]  literal_byte;
  logic [8:0]  match_length;
  logic [14:0] match_distance;
  logic        end_of_block;
  modport source (output valid, is_literal, literal_byte, match_length, match_distance,
                  end_of_block, input ready);
  modport sink   (input valid, is_literal, literal_byte, match_length, match_distance,
                  end_of_block, output ready);
endinterface

interface lzh_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/lzh_history.sv -----
// Byte history RAM: one write port, two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps
module lzh_history #(
  parameter int unsigned BUFFER_SIZE = 65536
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(BUFFER_SIZE)-1:0] wr_addr_i,
  input  logic [7:0]                     wr_data_i,
  input  logic [$clog2(BUFFER_SIZE)-1:0] rd_a_addr_i,
  input  logic [$clog2(BUFFER_SIZE)-1:0] rd_b_addr_i,
  output logic [7:0]                     rd_a_data_o,
  output logic [7:0]                     rd_b_data_o
);
  logic [7:0] mem [BUFFER_SIZE];
  logic [7:0] rd_a_q;
  logic [7:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem[rd_a_addr_i];
    rd_b_q <= mem[rd_b_addr_i];
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;
endmodule

// ----- rtl/lz77_hash_chain_encoder.sv -----
// LZ77 hash chain encoder, top level: sequencer, head table, chain links.
// Depends on lzh_pkg, lzh_if, lzh_history and the assertion macro header.
//
// Bytes of a block enter one transfer at a time on in_i. Once 258 bytes of
// lookahead are buffered, a data transfer yields one token on tok_o. After the
// last byte, each drain transfer yields one more token, and the final one
// is flagged end_of_block. Working on a token takes these steps:
// - Hashing and head lookup: three address/fold pairs, then head read and
//   update.
// - Each chain candidate is checked, compared one byte pair at a time and
//   evaluated, through the one shared byte comparator and history RAM reads.
// - The candidate check that ends the walk leads straight to the emit.
// - The emit writes the token register, and it waits while the token
//   register is still full.
// Data transfers that produce no token leave the encoder idle. in_i is not
// ready while a token is being worked on. The head table is cleared at once
// by per-entry valid bits; there is no clearing pass after reset.
`timescale 1ns / 1ps
`include "lz77_hash_chain_encoder_macros.svh"
module lz77_hash_chain_encoder #(
  parameter int unsigned WINDOW_SIZE = 32768,
  parameter int unsigned BUFFER_SIZE = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzh_in_if.sink    in_i,
  lzh_tok_if.source tok_o,
  lzh_cfg_if.sink   cfg_i
);
  localparam int unsigned HB = $clog2(BUFFER_SIZE);
  localparam int unsigned WB = $clog2(WINDOW_SIZE);
  localparam int unsigned PW = lzh_pkg::POS_W;
  localparam int unsigned LW = lzh_pkg::LEN_W;
  localparam int unsigned DW = lzh_pkg::DIST_W;
  localparam int unsigned KW = lzh_pkg::LIMIT_W;
  localparam int unsigned HW = lzh_pkg::HASH_W;
  localparam int unsigned NH = lzh_pkg::HASH_ENTRIES;

  lzh_pkg::state_e state_q, state_d;

  logic [PW-1:0] br_q, br_d;       // bytes received
  logic [PW-1:0] enc_q, enc_d;     // encode position
  logic          end_q, end_d;
  logic [KW-1:0] limit_q, limit_d;
  logic [PW-1:0] j_q, j_d;
  logic [DW-1:0] d_q, d_d;
  logic [LW-1:0] lim_q, lim_d;
  logic [LW-1:0] l_q, l_d;
  logic [LW-1:0] cap_q, cap_d;
  logic [LW-1:0] best_q, best_d;
  logic [DW-1:0] bdist_q, bdist_d;
  logic [KW-1:0] k_q, k_d;
  logic [1:0]    hk_q, hk_d;
  logic [HW-1:0] h_q, h_d;
  logic [7:0]    lit_q, lit_d;

  // token output register
  logic          tv_q, tv_d;
  logic          tlit_q, tlit_d;
  logic [7:0]    tbyte_q, tbyte_d;
  logic [LW-1:0] tlen_q, tlen_d;
  logic [DW-1:0] tdist_q, tdist_d;
  logic          teob_q, teob_d;

  logic [NH-1:0] hvld_q, hvld_d;
  logic [PW-1:0] head_mem [NH];
  logic [PW-1:0] link_mem [WINDOW_SIZE];
  logic [PW-1:0] head_rd_q;
  logic [PW-1:0] link_rd_q;
  logic          head_we, link_we;
  logic [PW-1:0] link_wdata;

  logic          hist_we;
  logic [HB-1:0] rd_a_addr, rd_b_addr;
  logic [7:0]    rd_a, rd_b;

  // combinational helpers
  logic [PW-1:0] avail, dist_full, enc_new;
  logic [LW-1:0] adv;
  logic          in_xfer, eob;

  lzh_history #(.BUFFER_SIZE(BUFFER_SIZE)) u_hist (
    .clk_i      (clk_i),
    .wr_en_i    (hist_we),
    .wr_addr_i  (br_q[HB-1:0]),
    .wr_data_i  (in_i.data_byte),
    .rd_a_addr_i(rd_a_addr),
    .rd_b_addr_i(rd_b_addr),
    .rd_a_data_o(rd_a),
    .rd_b_data_o(rd_b)
  );

  assign in_i.ready         = (state_q == lzh_pkg::ST_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign tok_o.valid        = tv_q;
  assign tok_o.is_literal   = tlit_q;
  assign tok_o.literal_byte = tbyte_q;
  assign tok_o.match_length = tlen_q;
  assign tok_o.match_distance = tdist_q;
  assign tok_o.end_of_block = teob_q;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign avail     = br_q - enc_q;
  assign dist_full = enc_q - j_q;
  assign adv       = (best_q < lzh_pkg::MIN_MATCH) ? LW'(1) : best_q;
  assign enc_new   = enc_q + PW'(adv);
  assign eob       = end_q && (enc_new == br_q);

  // sequencer and datapath
  always_comb begin
    state_d = state_q;
    br_d = br_q;       enc_d = enc_q;     end_d = end_q;   limit_d = limit_q;
    j_d = j_q;         d_d = d_q;         lim_d = lim_q;   l_d = l_q;
    cap_d = cap_q;     best_d = best_q;   bdist_d = bdist_q;
    k_d = k_q;         hk_d = hk_q;       h_d = h_q;       lit_d = lit_q;
    tv_d = tv_q;       tlit_d = tlit_q;   tbyte_d = tbyte_q;
    tlen_d = tlen_q;   tdist_d = tdist_q; teob_d = teob_q;
    hvld_d = hvld_q;
    hist_we = 1'b0;    head_we = 1'b0;    link_we = 1'b0;
    link_wdata = head_rd_q;
    rd_a_addr = HB'(j_q + PW'(l_q));
    rd_b_addr = HB'(enc_q + PW'(l_q));

    if (tv_q && tok_o.ready) begin
      tv_d = 1'b0;
    end
    if (cfg_i.valid && cfg_i.ready) begin
      limit_d = cfg_i.data;
    end

    case (state_q)
      lzh_pkg::ST_IDLE: begin
        hk_d = '0; h_d = '0; best_d = '0; bdist_d = '0; k_d = '0;
        if (in_xfer) begin
          if (in_i.kind == lzh_pkg::KIND_DATA) begin
            if (!end_q) begin
              hist_we = 1'b1;
              br_d    = br_q + PW'(1);
              end_d   = in_i.last_byte;
              if ((br_q + PW'(1) - enc_q) >= PW'(lzh_pkg::MAX_MATCH)) begin
                state_d = lzh_pkg::ST_HREAD;
              end
            end
          end else if (end_q && (enc_q != br_q)) begin
            state_d = lzh_pkg::ST_HREAD;
          end
        end
      end
      lzh_pkg::ST_HREAD: begin
        rd_a_addr = HB'(enc_q + PW'(hk_q));
        cap_d = (avail < PW'(lzh_pkg::MAX_MATCH)) ? LW'(avail) : lzh_pkg::MAX_MATCH;
        state_d = lzh_pkg::ST_HACC;
      end
      lzh_pkg::ST_HACC: begin
        // bytes past the end of the block hash as zero
        h_d = h_q * lzh_pkg::HASH_MULT + ((PW'(hk_q) < avail) ? rd_a : 8'd0);
        if (hk_q == 2'd0) begin
          lit_d = rd_a;
        end
        if (hk_q == 2'd2) begin
          state_d = lzh_pkg::ST_HEAD;
        end else begin
          hk_d    = hk_q + 2'd1;
          state_d = lzh_pkg::ST_HREAD;
        end
      end
      lzh_pkg::ST_HEAD: begin
        state_d = lzh_pkg::ST_HEADR;
      end
      lzh_pkg::ST_HEADR: begin
        // empty head points a full window back, ending the walk
        link_wdata = hvld_q[h_q] ? head_rd_q : (enc_q - PW'(WINDOW_SIZE));
        link_we    = 1'b1;
        head_we    = 1'b1;
        hvld_d[h_q] = 1'b1;
        j_d     = link_wdata;
        state_d = lzh_pkg::ST_CAND;
      end
      lzh_pkg::ST_CAND: begin
        l_d = '0;
        d_d = DW'(dist_full);
        lim_d = (PW'(cap_q) < dist_full) ? cap_q : LW'(dist_full);
        if ((k_q >= limit_q) || (dist_full == '0) ||
            (dist_full > PW'(WINDOW_SIZE - 1))) begin
          state_d = lzh_pkg::ST_EMIT;
        end else begin
          state_d = lzh_pkg::ST_CRD;
        end
      end
      lzh_pkg::ST_CRD: begin
        state_d = (l_q < lim_q) ? lzh_pkg::ST_CCMP : lzh_pkg::ST_EVAL;
      end
      lzh_pkg::ST_CCMP: begin
        if (rd_a == rd_b) begin
          l_d     = l_q + LW'(1);
          state_d = lzh_pkg::ST_CRD;
        end else begin
          state_d = lzh_pkg::ST_EVAL;
        end
      end
      lzh_pkg::ST_EVAL: begin
        // link read of j_q has settled by now
        j_d     = link_rd_q;
        k_d     = k_q + KW'(1);
        state_d = lzh_pkg::ST_CAND;
        if (l_q > best_q) begin
          best_d  = l_q;
          bdist_d = d_q;
          if (l_q == lzh_pkg::MAX_MATCH) begin
            state_d = lzh_pkg::ST_EMIT;
          end
        end
      end
      lzh_pkg::ST_EMIT: begin
        if (!tv_q || tok_o.ready) begin
          tv_d    = 1'b1;
          tlit_d  = (best_q < lzh_pkg::MIN_MATCH);
          tbyte_d = tlit_d ? lit_q : 8'd0;
          tlen_d  = tlit_d ? '0 : best_q;
          tdist_d = tlit_d ? '0 : bdist_q;
          teob_d  = eob;
          enc_d   = enc_new;
          if (eob) begin
            hvld_d = '0;
            br_d   = '0;
            enc_d  = '0;
            end_d  = 1'b0;
          end
          state_d = lzh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lzh_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzh_pkg::ST_IDLE;
      br_q    <= '0;
      enc_q   <= '0;
      end_q   <= 1'b0;
      limit_q <= lzh_pkg::CHAIN_LIMIT_RST;
      tv_q    <= 1'b0;
      hvld_q  <= '0;
    end else begin
      state_q <= state_d;
      br_q    <= br_d;
      enc_q   <= enc_d;
      end_q   <= end_d;
      limit_q <= limit_d;
      tv_q    <= tv_d;
      hvld_q  <= hvld_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    j_q <= j_d;       d_q <= d_d;         lim_q <= lim_d;   l_q <= l_d;
    cap_q <= cap_d;   best_q <= best_d;   bdist_q <= bdist_d;
    k_q <= k_d;       hk_q <= hk_d;       h_q <= h_d;       lit_q <= lit_d;
    tlit_q <= tlit_d; tbyte_q <= tbyte_d; tlen_q <= tlen_d;
    tdist_q <= tdist_d; teob_q <= teob_d;
  end

  // head table and chain link RAMs
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[h_q] <= enc_q;
    end
    head_rd_q <= head_mem[h_q];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[enc_q[WB-1:0]] <= link_wdata;
    end
    link_rd_q <= link_mem[j_q[WB-1:0]];
  end

  `LZH_ASSERT_NOW(a_match_shape, tv_q && !tlit_q,
    (tlen_q >= lzh_pkg::MIN_MATCH) && (tlen_q <= lzh_pkg::MAX_MATCH) &&
    (PW'(tlen_q) <= PW'(tdist_q)), "match token out of range")
  `LZH_ASSERT_NOW(a_cmp_bound, state_q == lzh_pkg::ST_CCMP, l_q < lim_q,
    "compare ran past its limit")
  `LZH_ASSERT_NXT(a_eob_clear,
    (state_q == lzh_pkg::ST_EMIT) && (!tv_q || tok_o.ready) && eob,
    (br_q == '0) && !end_q && (hvld_q == '0), "block state not cleared")
  `LZH_ASSERT_NOW(a_lookahead, state_q == lzh_pkg::ST_HREAD,
    end_q || (avail >= PW'(lzh_pkg::MAX_MATCH)), "token started without lookahead")
endmodule
